// ===== src/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int DATA_W = 32;

  // operation codes carried in s_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // error codes in the result word
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t item;
  } spq_cmd_t;

endpackage
`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
`default_nettype none
// channel | dir | tdata (low bit up)                                   | tuser
// s_axis  | in  | item_value[31:0], item_key[63:32]                    | operation[0]
// m_axis  | out | head_value[31:0], head_key[63:32], entry_count[70:64],
//         |     | queue_empty[71], error_code[73:72], zero[79:74]      | -
// one word is taken per cycle while s_tready is high; its result appears in the output register on
// the next cycle, since every cell updates its slot in parallel from its
// neighbors and the broadcast key
// s_tready drops only while a result waits in the output register and m_tready is low
// rst (synchronous) empties the queue and the output register; slot contents are not cleared
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // item_value, item_key
  input  wire logic [0:0]  s_tuser,   // operation
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [79:0] m_tdata    // head_value, head_key, entry_count, queue_empty, error_code
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             accept;
  logic             op;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       err;
  spq_cmd_t         cmd;
  logic             take       [CAPACITY];
  entry_t           entries    [CAPACITY];
  entry_t           entries_nx [CAPACITY];
  logic [CNT_W+6:0] count_ext;
  entry_t           head;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser[0];
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;

  assign cmd.insert     = accept && (op == OP_INSERT) && !full;
  assign cmd.remove     = accept && (op == OP_REMOVE) && !empty;
  assign cmd.item.value = s_tdata[31:0];
  assign cmd.item.key   = s_tdata[63:32];

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    err = ERR_NONE;
    if (op == OP_INSERT && full) begin
      err = ERR_FULL;
    end else if (op == OP_REMOVE && empty) begin
      err = ERR_EMPTY;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_take;
    entry_t prev_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign prev_take  = 1'b0;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_take  = take[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .prev_take   (prev_take),
      .prev_entry  (prev_entry),
      .right_entry (right_entry),
      .take        (take[i]),
      .entry       (entries[i]),
      .entry_next  (entries_nx[i])
    );
  end

  assign count_ext = {7'd0, count_next};
  assign head      = (count_next == '0) ? '0 : entries_nx[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, err, (count_next == '0), count_ext[6:0], head.key, head.value};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> $signed(entries[0].key) <= $signed(entries[1].key))
    else $error("head entry out of order");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_REMOVE && empty |=> m_tdata[73:72] == ERR_EMPTY && m_tdata[71])
    else $error("remove on empty queue not flagged");

endmodule
`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic             clk,
  input  wire spq_cmd_t         cmd,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             prev_take,
  input  wire entry_t           prev_entry,
  input  wire entry_t           right_entry,
  output      logic             take,
  output      entry_t           entry,
  output      entry_t           entry_next
);

  logic occupied;

  assign occupied = count > CNT_W'(INDEX);

  // an empty slot or a strictly greater key makes room for the new word
  assign take = !occupied || ($signed(entry.key) > $signed(cmd.item.key));

  always_comb begin
    entry_next = entry;
    if (cmd.insert && take) begin
      entry_next = prev_take ? prev_entry : cmd.item;
    end else if (cmd.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire
